[src/scsp_pkg.sv]
// shared constants and controller-to-datapath command type for the subpixel peak block
`default_nettype none
package scsp_pkg;

    localparam int SCORE_W           = 16;
    localparam int COORD_W           = 16;
    localparam int SPREAD_W          = 20;
    localparam int SUM_W             = 20;
    localparam int PART_W            = 18;
    localparam int OUT_W             = 24;
    localparam int FRACTION_BITS_DEF = 8;

    typedef logic [1:0] idx_t;

    localparam idx_t AXIS_Z = 2'd0;
    localparam idx_t AXIS_Y = 2'd1;
    localparam idx_t AXIS_X = 2'd2;

    typedef struct packed {
        logic load;
        logic first;
        logic last;
        idx_t zi;
        idx_t yi;
        idx_t xi;
        logic sel;
        logic rank;
        logic prep;
        logic div_step;
        logic fin;
        logic publish;
        idx_t axis;
    } scsp_cmd_t;

endpackage
`default_nettype wire

[src/score_cube_subpixel_peak_top.sv]
// top level of the 3x3x3 score cube subpixel peak block
//
//  channel | signals                                  | dir | moves
//  in      | in_valid in_ready score_value center_x/y/z | in  | one cell item
//  out     | out_valid out_ready sub_x sub_y sub_z      | out | one result item per cube
//  cfg     | cfg_wr_en cfg_wr_data                    | in  | min_score_spread
//
//  cells are taken one per cycle while in the load state; after the 27th the three axes
//  are evaluated in turn on the shared radix-2 divider, and no cells are taken until
//  the cube's result is published
//  reset clears the cell count, the output valid and the threshold; no clearing pass
//  a stalled result sits in the output register while the next cube loads; the
//  following result waits for it before being published
`default_nettype none
module score_cube_subpixel_peak_top
    import scsp_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [SPREAD_W-1:0] cfg_wr_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [SCORE_W-1:0]  score_value,
    input  wire logic [COORD_W-1:0]  center_x,
    input  wire logic [COORD_W-1:0]  center_y,
    input  wire logic [COORD_W-1:0]  center_z,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [OUT_W-1:0]         sub_x,
    output logic [OUT_W-1:0]         sub_y,
    output logic [OUT_W-1:0]         sub_z
);

    scsp_cmd_t cmd;

    scsp_ctrl #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd      (cmd)
    );

    scsp_datapath #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .score_value(score_value),
        .center_x   (center_x),
        .center_y   (center_y),
        .center_z   (center_z),
        .sub_x      (sub_x),
        .sub_y      (sub_y),
        .sub_z      (sub_z)
    );

endmodule
`default_nettype wire

[src/scsp_ctrl.sv]
// controller: cell counting, per-axis sequencing, divider count and output valid
`default_nettype none
module scsp_ctrl
    import scsp_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output scsp_cmd_t      cmd
);

    localparam int QW = FRACTION_BITS + 2;
    localparam int CW = $clog2(QW);

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_SEL  = 3'd1;
    localparam logic [2:0] ST_RANK = 3'd2;
    localparam logic [2:0] ST_PREP = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;
    localparam logic [2:0] ST_PUB  = 3'd6;

    logic [2:0]    state_reg, state_next;
    idx_t          zi_reg, zi_next, yi_reg, yi_next, xi_reg, xi_next;
    idx_t          axis_reg, axis_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic          accept, last_cell, publish;

    assign in_ready  = (state_reg == ST_LOAD);
    assign accept    = in_valid && in_ready;
    assign last_cell = (zi_reg == 2'd2) && (yi_reg == 2'd2) && (xi_reg == 2'd2);
    assign publish   = (state_reg == ST_PUB) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        zi_next    = zi_reg;
        yi_next    = yi_reg;
        xi_next    = xi_reg;
        axis_next  = axis_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (zi_reg == 2'd2)
                    begin
                        zi_next = 2'd0;
                        if (yi_reg == 2'd2)
                        begin
                            yi_next = 2'd0;
                            xi_next = (xi_reg == 2'd2) ? 2'd0 : xi_reg + 2'd1;
                        end
                        else
                        begin
                            yi_next = yi_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        zi_next = zi_reg + 2'd1;
                    end
                    if (last_cell)
                    begin
                        state_next = ST_SEL;
                        axis_next  = AXIS_Z;
                    end
                end
            end
            ST_SEL:  state_next = ST_RANK;
            ST_RANK: state_next = ST_PREP;
            ST_PREP:
            begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                if (cnt_reg == CW'(QW - 1))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_FIN:
            begin
                if (axis_reg == AXIS_X)
                begin
                    state_next = ST_PUB;
                end
                else
                begin
                    state_next = ST_SEL;
                    axis_next  = axis_reg + 2'd1;
                end
            end
            ST_PUB:
            begin
                if (publish)
                begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        cmd.load     = accept;
        cmd.first    = (zi_reg == 2'd0) && (yi_reg == 2'd0) && (xi_reg == 2'd0);
        cmd.last     = last_cell;
        cmd.zi       = zi_reg;
        cmd.yi       = yi_reg;
        cmd.xi       = xi_reg;
        cmd.sel      = (state_reg == ST_SEL);
        cmd.rank     = (state_reg == ST_RANK);
        cmd.prep     = (state_reg == ST_PREP);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.fin      = (state_reg == ST_FIN);
        cmd.publish  = publish;
        cmd.axis     = axis_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            zi_reg        <= '0;
            yi_reg        <= '0;
            xi_reg        <= '0;
            axis_reg      <= AXIS_Z;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            zi_reg        <= zi_next;
            yi_reg        <= yi_next;
            xi_reg        <= xi_next;
            axis_reg      <= axis_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_cell) |=> (state_reg == ST_SEL && axis_reg == AXIS_Z))
        else $error("last cell did not start evaluation");
    a_pub_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        publish |=> out_valid_reg)
        else $error("published result not valid");
    a_pub_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUB && out_valid_reg && !out_ready) |=> (state_reg == ST_PUB))
        else $error("result overwritten while output stalled");
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg < CW'(QW)))
        else $error("divider count out of range");
`endif

endmodule
`default_nettype wire

[src/scsp_datapath.sv]
// datapath: plane sums, ranking, centroid numerator, shared divider and clamping
`default_nettype none
module scsp_datapath
    import scsp_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire scsp_cmd_t           cmd,
    input  wire logic                cfg_wr_en,
    input  wire logic [SPREAD_W-1:0] cfg_wr_data,
    input  wire logic [SCORE_W-1:0]  score_value,
    input  wire logic [COORD_W-1:0]  center_x,
    input  wire logic [COORD_W-1:0]  center_y,
    input  wire logic [COORD_W-1:0]  center_z,
    output logic [OUT_W-1:0]         sub_x,
    output logic [OUT_W-1:0]         sub_y,
    output logic [OUT_W-1:0]         sub_z
);

    localparam int QW = FRACTION_BITS + 2;
    localparam int NW = FRACTION_BITS + 24;
    localparam int DW = 22;
    localparam int RW = FRACTION_BITS + 18;
    localparam logic [63:0] LIM_FULL = 64'(65535) << FRACTION_BITS;
    localparam logic [OUT_W-1:0] LIM = (LIM_FULL > 64'hFFFFFF) ? 24'hFFFFFF
                                                             : LIM_FULL[OUT_W-1:0];

    logic [SPREAD_W-1:0] spread_reg;
    logic [SUM_W-1:0]    plane_reg [3];
    logic [SUM_W-1:0]    plane_next [3];
    logic [PART_W-1:0]   sy_reg [3][3];
    logic [PART_W-1:0]   sy_next [3][3];
    logic [PART_W-1:0]   sx_reg [3][3];
    logic [PART_W-1:0]   sx_next [3][3];
    logic [COORD_W-1:0]  cx_reg, cy_reg, cz_reg;
    logic [SUM_W-1:0]    s_reg [3];
    logic [SUM_W-1:0]    s_next [3];
    idx_t                zh_reg, zm_reg, hi_reg, md_reg;
    idx_t                rl, rh, rm, rt;
    logic [SUM_W-1:0]    sh_reg, sm_reg;
    logic                pass_reg;
    logic [SUM_W:0]      den;
    logic [DW-1:0]       num;
    logic [NW-1:0]       dividend;
    logic [DW-1:0]       d_reg, rem_reg;
    logic [QW-1:0]       nlo_reg;
    logic [DW:0]         trial;
    logic                ge;
    logic [COORD_W-1:0]  center;
    logic signed [RW-1:0] res;
    logic [OUT_W-1:0]    res_out;
    logic [OUT_W-1:0]    rx_reg, ry_reg, rz_reg;
    logic [OUT_W-1:0]    ox_reg, oy_reg, oz_reg;

    function automatic logic [DW-1:0] times_idx(input logic [SUM_W-1:0] v, input idx_t i);
        logic [DW-1:0] r;
        unique case (i)
            2'd1:    r = DW'(v);
            2'd2:    r = DW'(v) << 1;
            default: r = '0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            plane_next[a] = (cmd.first ? '0 : plane_reg[a])
                          + ((cmd.zi == idx_t'(a)) ? SUM_W'(score_value) : '0);
            for (int z = 0; z < 3; z++)
            begin
                sy_next[a][z] = (cmd.first ? '0 : sy_reg[a][z])
                    + ((cmd.yi == idx_t'(a) && cmd.zi == idx_t'(z)) ? PART_W'(score_value) : '0);
                sx_next[a][z] = (cmd.first ? '0 : sx_reg[a][z])
                    + ((cmd.xi == idx_t'(a) && cmd.zi == idx_t'(z)) ? PART_W'(score_value) : '0);
            end
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            unique case (cmd.axis)
                AXIS_Y:  s_next[a] = SUM_W'(sy_reg[a][zh_reg]) + SUM_W'(sy_reg[a][zm_reg]);
                AXIS_X:  s_next[a] = SUM_W'(sx_reg[a][zh_reg]) + SUM_W'(sx_reg[a][zm_reg]);
                default: s_next[a] = plane_reg[a];
            endcase
        end
    end

    // three-way compare network, equal sums are never swapped
    always_comb
    begin
        rl = 2'd0;
        rh = 2'd1;
        rm = 2'd2;
        rt = 2'd0;
        if (s_reg[rm] < s_reg[rl])
        begin
            rt = rm; rm = rl; rl = rt;
        end
        if (s_reg[rh] < s_reg[rl])
        begin
            rt = rh; rh = rl; rl = rt;
        end
        if (s_reg[rh] < s_reg[rm])
        begin
            rt = rh; rh = rm; rm = rt;
        end
    end

    assign den      = {1'b0, sh_reg} + {1'b0, sm_reg};
    assign num      = times_idx(sm_reg, md_reg) + times_idx(sh_reg, hi_reg);
    assign dividend = (NW'(num) << (FRACTION_BITS + 1)) + NW'(den);

    assign trial = {rem_reg, nlo_reg[QW-1]};
    assign ge    = trial >= {1'b0, d_reg};

    always_comb
    begin
        unique case (cmd.axis)
            AXIS_Y:  center = cy_reg;
            AXIS_X:  center = cx_reg;
            default: center = cz_reg;
        endcase
    end

    always_comb
    begin
        if (pass_reg)
        begin
            res = ((RW'(signed'({2'b00, center})) - RW'(1)) <<< FRACTION_BITS)
                + signed'(RW'(nlo_reg));
        end
        else
        begin
            res = signed'(RW'({2'b00, center}) << FRACTION_BITS);
        end
        if (res < 0)
        begin
            res_out = '0;
        end
        else if (64'(unsigned'(res)) > 64'(LIM))
        begin
            res_out = LIM;
        end
        else
        begin
            res_out = OUT_W'(unsigned'(res));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spread_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            spread_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            plane_reg <= plane_next;
            sy_reg    <= sy_next;
            sx_reg    <= sx_next;
            if (cmd.last)
            begin
                cx_reg <= center_x;
                cy_reg <= center_y;
                cz_reg <= center_z;
            end
        end
        if (cmd.sel)
        begin
            s_reg <= s_next;
        end
        if (cmd.rank)
        begin
            hi_reg <= rh;
            md_reg <= rm;
            sh_reg <= s_reg[rh] - s_reg[rl];
            sm_reg <= s_reg[rm] - s_reg[rl];
            if (cmd.axis == AXIS_Z)
            begin
                zh_reg <= rh;
                zm_reg <= rm;
            end
        end
        if (cmd.prep)
        begin
            pass_reg <= SUM_W'(sh_reg) > SUM_W'(spread_reg);
            d_reg    <= {den, 1'b0};
            rem_reg  <= dividend[NW-1:QW];
            nlo_reg  <= dividend[QW-1:0];
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? DW'(trial - {1'b0, d_reg}) : trial[DW-1:0];
            nlo_reg <= {nlo_reg[QW-2:0], ge};
        end
        if (cmd.fin)
        begin
            unique case (cmd.axis)
                AXIS_Y:  ry_reg <= res_out;
                AXIS_X:  rx_reg <= res_out;
                default: rz_reg <= res_out;
            endcase
        end
        if (cmd.publish)
        begin
            ox_reg <= rx_reg;
            oy_reg <= ry_reg;
            oz_reg <= rz_reg;
        end
    end

    assign sub_x = ox_reg;
    assign sub_y = oy_reg;
    assign sub_z = oz_reg;

endmodule
`default_nettype wire

[tb/sv/score_cube_subpixel_peak_top_tb.sv]
// testbench for the score cube subpixel peak block: directed and random cubes against a predictor
`timescale 1ns / 1ps
module score_cube_subpixel_peak_top_tb;
    import scsp_pkg::*;

    localparam int FB       = FRACTION_BITS_DEF;
    localparam int CELLS    = 27;
    localparam int DRAIN    = 100;
    localparam longint LIM  = 64'd65535 << FB;

    typedef struct {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic [OUT_W-1:0] z;
    } peak_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [SPREAD_W-1:0] cfg_wr_data;
    logic                in_valid;
    logic                in_ready;
    logic [SCORE_W-1:0]  score_value;
    logic [COORD_W-1:0]  center_x;
    logic [COORD_W-1:0]  center_y;
    logic [COORD_W-1:0]  center_z;
    logic                out_valid;
    logic                out_ready;
    logic [OUT_W-1:0]    sub_x;
    logic [OUT_W-1:0]    sub_y;
    logic [OUT_W-1:0]    sub_z;

    score_cube_subpixel_peak_top uut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready), .score_value(score_value),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .sub_x(sub_x), .sub_y(sub_y), .sub_z(sub_z)
    );

    peak_t               peak_queue[$];
    int                  mismatches = 0;
    bit                  quiet = 0;
    logic [SPREAD_W-1:0] spread_model = '0;
    logic [SCORE_W-1:0]  cube_cells[CELLS];
    logic [SUM_W-1:0]    plane_acc[3];
    int                  cell_count = 0;
    logic [SCORE_W-1:0]  cube_buf[CELLS];

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        score_value <= '0;
        center_x    <= '0;
        center_y    <= '0;
        center_z    <= '0;
        out_ready   <= 1'b0;
        for (int i = 0; i < 3; i++)
            plane_acc[i] = '0;
    end

    function automatic logic [OUT_W-1:0] axis_peak(input longint unsigned center,
        input longint unsigned s0, input longint unsigned s1, input longint unsigned s2,
        output int hi, output int md);
        longint unsigned s[3];
        int l, h, m, t;
        longint unsigned sh, sm, den, num, frac;
        longint res;
        s[0] = s0; s[1] = s1; s[2] = s2;
        l = 0; h = 1; m = 2;
        if (s[m] < s[l]) begin t = m; m = l; l = t; end
        if (s[h] < s[l]) begin t = h; h = l; l = t; end
        if (s[h] < s[m]) begin t = h; h = m; m = t; end
        hi = h; md = m;
        sh = s[h] - s[l];
        sm = s[m] - s[l];
        if (!(sh > spread_model))
            res = longint'(center) << FB;
        else
        begin
            den  = sh + sm;
            num  = sm * m + sh * h;
            frac = ((num << (FB + 1)) + den) / (2 * den);
            res  = ((longint'(center) - 1) <<< FB) + longint'(frac);
        end
        if (res < 0)
            return '0;
        if (res > LIM)
            return LIM[OUT_W-1:0];
        return res[OUT_W-1:0];
    endfunction

    task automatic predict_cell(input logic [SCORE_W-1:0] s, input logic [COORD_W-1:0] cx,
        input logic [COORD_W-1:0] cy, input logic [COORD_W-1:0] cz);
        peak_t p;
        int zh, zm, h, m;
        longint unsigned acc[3];
        int pl[2];
        cube_cells[cell_count] = s;
        plane_acc[cell_count % 3] = plane_acc[cell_count % 3] + s;
        if (cell_count < CELLS - 1)
        begin
            cell_count++;
            return;
        end
        p.z = axis_peak(cz, plane_acc[0], plane_acc[1], plane_acc[2], zh, zm);
        pl[0] = zm; pl[1] = zh;
        for (int a = 0; a < 3; a++)
        begin
            acc[a] = 0;
            for (int r = 0; r < 2; r++)
                for (int b = 0; b < 3; b++)
                    acc[a] += cube_cells[b * 9 + a * 3 + pl[r]];
        end
        p.y = axis_peak(cy, acc[0], acc[1], acc[2], h, m);
        for (int a = 0; a < 3; a++)
        begin
            acc[a] = 0;
            for (int r = 0; r < 2; r++)
                for (int b = 0; b < 3; b++)
                    acc[a] += cube_cells[a * 9 + b * 3 + pl[r]];
        end
        p.x = axis_peak(cx, acc[0], acc[1], acc[2], h, m);
        peak_queue.push_back(p);
        cell_count = 0;
        for (int i = 0; i < 3; i++)
            plane_acc[i] = '0;
    endtask

    task automatic send_cell(input logic [SCORE_W-1:0] s, input logic [COORD_W-1:0] cx,
        input logic [COORD_W-1:0] cy, input logic [COORD_W-1:0] cz);
        while (!quiet && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        score_value <= s;
        center_x    <= cx;
        center_y    <= cy;
        center_z    <= cz;
        do
            @(posedge clk);
        while (!in_ready);
        predict_cell(s, cx, cy, cz);
    endtask

    // sends cube_buf, center on every cell but only the last one counts
    task automatic send_cube(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
        input logic [COORD_W-1:0] cz);
        for (int k = 0; k < CELLS; k++)
            if (k == CELLS - 1)
                send_cell(cube_buf[k], cx, cy, cz);
            else
                send_cell(cube_buf[k], COORD_W'($urandom), COORD_W'($urandom),
                          COORD_W'($urandom));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (peak_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_spread(input logic [SPREAD_W-1:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        spread_model = v;
        @(posedge clk);
    endtask

    task automatic fill_cube(input int style);
        int peak;
        peak = $urandom_range(CELLS - 1);
        for (int k = 0; k < CELLS; k++)
            case (style)
                0: cube_buf[k] = SCORE_W'($urandom);
                1: cube_buf[k] = SCORE_W'($urandom_range(15));
                2: cube_buf[k] = (k == peak) ? 16'(40000 + $urandom_range(25535))
                                             : 16'($urandom_range(2000));
                3: cube_buf[k] = 16'((k % 3 == peak % 3) ? 30000 + $urandom_range(30000)
                                                         : $urandom_range(30000));
                default: cube_buf[k] = 16'hffff;
            endcase
    endtask

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
        input logic [OUT_W-1:0] want);
        $display("%0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
        out_ready <= quiet || ($urandom_range(99) >= 16);

    always @(posedge clk)
    begin
        peak_t p;
        if (rst_n && out_valid && out_ready)
        begin
            if (peak_queue.size() == 0)
                report_mismatch("unexpected item sub_x", sub_x, '0);
            else
            begin
                p = peak_queue.pop_front();
                if (sub_x !== p.x) report_mismatch("sub_x", sub_x, p.x);
                if (sub_y !== p.y) report_mismatch("sub_y", sub_y, p.y);
                if (sub_z !== p.z) report_mismatch("sub_z", sub_z, p.z);
            end
        end
    end

    task automatic test_directed();
        for (int k = 0; k < CELLS; k++)
            cube_buf[k] = '0;
        send_cube(16'd0, 16'd0, 16'd0);
        fill_cube(4);
        send_cube(16'hffff, 16'hffff, 16'hffff);
        // single peak near the low corner, center zero saturates low
        for (int k = 0; k < CELLS; k++)
            cube_buf[k] = (k == 0) ? 16'hffff : 16'd0;
        send_cube(16'd0, 16'd0, 16'd0);
        // peak at the far corner, top center saturates high
        for (int k = 0; k < CELLS; k++)
            cube_buf[k] = (k == CELLS - 1) ? 16'hffff : 16'd1;
        send_cube(16'hffff, 16'hffff, 16'hffff);
        // two equal planes tie
        for (int k = 0; k < CELLS; k++)
            cube_buf[k] = (k % 3 == 2) ? 16'd0 : 16'd500;
        send_cube(16'd100, 16'd200, 16'd300);
        write_spread({SPREAD_W{1'b1}});
        fill_cube(0);
        send_cube(16'd1234, 16'd4321, 16'd777);
        write_spread(20'd4499);
        for (int k = 0; k < CELLS; k++)
            cube_buf[k] = (k % 3 == 1) ? 16'd500 : 16'd0;
        send_cube(16'd10, 16'd10, 16'd10);
        write_spread(20'd4500);
        send_cube(16'd10, 16'd10, 16'd10);
    endtask

    task automatic run_random(input int cubes);
        logic [COORD_W-1:0] c[3];
        for (int n = 0; n < cubes; n++)
        begin
            fill_cube($urandom_range(4));
            for (int i = 0; i < 3; i++)
                case ($urandom_range(7))
                    0: c[i] = '0;
                    1: c[i] = 16'hffff;
                    default: c[i] = COORD_W'($urandom);
                endcase
            send_cube(c[0], c[1], c[2]);
        end
    endtask

    task automatic test_random();
        write_spread('0);
        run_random(20);
        quiet = 1;
        run_random(10);
        quiet = 0;
        write_spread(SPREAD_W'($urandom_range(200000)));
        run_random(20);
        write_spread(SPREAD_W'($urandom_range(5000)));
        run_random(5);
        write_spread({SPREAD_W{1'b1}});
        run_random(4);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        wait_drained();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
